>>> rtl/hsv_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines: assertion macros
// shared macros for the concurrent checks on the converter ports
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HSVRGB_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("hsv_to_rgb_converter: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define HSVRGB_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("hsv_to_rgb_converter: next-cycle check failed");

`endif

>>> rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg: shared types, constants and helpers
// fixed-point format, sector codes, clamp and byte scaling
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int UNIT_W      = FRAC_BITS + 1;   // holds 0..one inclusive
	localparam int IN_W        = 32;
	localparam int BYTE_W      = 8;
	localparam int PIPE_STAGES = 4;
	localparam int CNT_W       = $clog2(PIPE_STAGES + 1);

	typedef logic [UNIT_W-1:0]    unit_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [2:0]           sector_t;
	typedef logic [BYTE_W-1:0]    byte_t;

	localparam unit_t            UNIT_ONE = unit_t'(1) << FRAC_BITS;
	localparam logic [IN_W-1:0]  WORD_ONE = IN_W'(1) << FRAC_BITS;

	// hue sectors, sector wrap marks hue of exactly one
	localparam sector_t SECT_RED_YEL = 3'd0;
	localparam sector_t SECT_YEL_GRN = 3'd1;
	localparam sector_t SECT_GRN_CYN = 3'd2;
	localparam sector_t SECT_CYN_BLU = 3'd3;
	localparam sector_t SECT_BLU_MAG = 3'd4;
	localparam sector_t SECT_MAG_RED = 3'd5;
	localparam sector_t SECT_WRAP    = 3'd6;

	// clamp a signed fixed-point word to 0..one
	function automatic unit_t clamp_unit(input logic [IN_W-1:0] raw);
		unit_t res;
		if (raw[IN_W-1]) begin
			res = '0;
		end else if (raw > WORD_ONE) begin
			res = UNIT_ONE;
		end else begin
			res = raw[UNIT_W-1:0];
		end
		return res;
	endfunction

	// floor(255 * c) with clamp to one byte
	function automatic byte_t to_byte(input unit_t c);
		logic [UNIT_W+7:0] prod;
		logic [8:0]        q;
		prod = {c, 8'd0} - {8'd0, c};
		q    = prod[FRAC_BITS +: 9];
		return (q > 9'd255) ? 8'hff : q[7:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to RGB pixel converter, four-stage pipeline
// inputs pass stage registers s1..s4 before the result shows; one pixel per
// cycle unless stalled; multipliers in stages 2 and 3; stalls back up stage
// by stage; reset clears the stage valid bits only, the pipe comes up empty
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
	input  wire                      clk,
	input  wire                      arst_n,
	// hsv side
	input  wire                      hsv_valid,
	output logic                     hsv_ready,
	input  wire  signed [31:0]       hue,
	input  wire  signed [31:0]       saturation,
	input  wire  signed [31:0]       brightness,
	// rgb side
	output logic                     rgb_valid,
	input  wire                      rgb_ready,
	output hsvrgb_pkg::byte_t        red,
	output hsvrgb_pkg::byte_t        green,
	output hsvrgb_pkg::byte_t        blue
);

	// per-stage valid and advance; a stage takes new data when empty or
	// when the stage after it moves on, so bubbles collapse under a stall
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s4  = !valid_s4 || rgb_ready;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign hsv_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= hsv_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: clamp inputs, hue times six into sector and fraction
	// ------------------------------------------------------------------
	hsvrgb_pkg::unit_t               h_c, s_c, v_c;
	logic [hsvrgb_pkg::UNIT_W+2:0]   h6;
	hsvrgb_pkg::sector_t             sect_raw, sect_c;
	hsvrgb_pkg::frac_t               frac_c;

	assign h_c = hsvrgb_pkg::clamp_unit(hue);
	assign s_c = hsvrgb_pkg::clamp_unit(saturation);
	assign v_c = hsvrgb_pkg::clamp_unit(brightness);

	// times six as (h << 2) + (h << 1)
	assign h6 = {1'b0, h_c, 2'b00} + {2'b00, h_c, 1'b0};
	assign sect_raw = h6[hsvrgb_pkg::FRAC_BITS +: 3];

	always_comb begin
		sect_c = sect_raw;
		frac_c = h6[hsvrgb_pkg::FRAC_BITS-1:0];
		// hue of exactly one folds back onto the start of the wheel
		if (sect_raw >= hsvrgb_pkg::SECT_WRAP) begin
			sect_c = hsvrgb_pkg::SECT_RED_YEL;
			frac_c = '0;
		end
	end

	hsvrgb_pkg::unit_t   s_s1, v_s1;
	hsvrgb_pkg::frac_t   f_s1;
	hsvrgb_pkg::sector_t sect_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			s_s1    <= s_c;
			v_s1    <= v_c;
			f_s1    <= frac_c;
			sect_s1 <= sect_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: s*f and s*(1-f), then the three (1 - ...) factors
	// ------------------------------------------------------------------
	hsvrgb_pkg::unit_t f_u, f_inv, sf, sf_inv;

	assign f_u   = {1'b0, f_s1};
	assign f_inv = hsvrgb_pkg::UNIT_ONE - f_u;

	hsvrgb_fxmul u_mul_sf (
		.a (s_s1),
		.b (f_u),
		.p (sf)
	);

	hsvrgb_fxmul u_mul_sfinv (
		.a (s_s1),
		.b (f_inv),
		.p (sf_inv)
	);

	hsvrgb_pkg::unit_t   v_s2, fx_s2, fy_s2, fz_s2;
	hsvrgb_pkg::sector_t sect_s2;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			v_s2    <= v_s1;
			fx_s2   <= hsvrgb_pkg::UNIT_ONE - s_s1;     // 1 - s
			fy_s2   <= hsvrgb_pkg::UNIT_ONE - sf;       // 1 - s*f
			fz_s2   <= hsvrgb_pkg::UNIT_ONE - sf_inv;   // 1 - s*(1-f)
			sect_s2 <= sect_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: scale the three factors by v
	// ------------------------------------------------------------------
	hsvrgb_pkg::unit_t x_c, y_c, z_c;

	hsvrgb_fxmul u_mul_x (
		.a (v_s2),
		.b (fx_s2),
		.p (x_c)
	);

	hsvrgb_fxmul u_mul_y (
		.a (v_s2),
		.b (fy_s2),
		.p (y_c)
	);

	hsvrgb_fxmul u_mul_z (
		.a (v_s2),
		.b (fz_s2),
		.p (z_c)
	);

	hsvrgb_pkg::unit_t   v_s3, x_s3, y_s3, z_s3;
	hsvrgb_pkg::sector_t sect_s3;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			v_s3    <= v_s2;
			x_s3    <= x_c;
			y_s3    <= y_c;
			z_s3    <= z_c;
			sect_s3 <= sect_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: route sources by sector, scale to bytes; output register
	// ------------------------------------------------------------------
	hsvrgb_pkg::unit_t r_c, g_c, b_c;

	always_comb begin
		unique case (sect_s3)
			hsvrgb_pkg::SECT_RED_YEL: begin
				r_c = v_s3; g_c = z_s3; b_c = x_s3;
			end
			hsvrgb_pkg::SECT_YEL_GRN: begin
				r_c = y_s3; g_c = v_s3; b_c = x_s3;
			end
			hsvrgb_pkg::SECT_GRN_CYN: begin
				r_c = x_s3; g_c = v_s3; b_c = z_s3;
			end
			hsvrgb_pkg::SECT_CYN_BLU: begin
				r_c = x_s3; g_c = y_s3; b_c = v_s3;
			end
			hsvrgb_pkg::SECT_BLU_MAG: begin
				r_c = z_s3; g_c = x_s3; b_c = v_s3;
			end
			// magenta to red, and codes that never occur after the wrap
			default: begin
				r_c = v_s3; g_c = x_s3; b_c = y_s3;
			end
		endcase
	end

	hsvrgb_pkg::byte_t red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			red_s4   <= hsvrgb_pkg::to_byte(r_c);
			green_s4 <= hsvrgb_pkg::to_byte(g_c);
			blue_s4  <= hsvrgb_pkg::to_byte(b_c);
		end
	end

	// result transfer straight from the last stage
	assign rgb_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

endmodule

`default_nettype wire

>>> rtl/hsvrgb_fxmul.sv
// ----------------------------------------------------------------------------
// hsvrgb_fxmul: unit-range fixed-point multiply
// product of two 0..one values, truncated back to the fraction width
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_fxmul (
	input  wire hsvrgb_pkg::unit_t a,
	input  wire hsvrgb_pkg::unit_t b,
	output hsvrgb_pkg::unit_t      p
);

	logic [2*hsvrgb_pkg::UNIT_W-1:0] prod;

	assign prod = {{hsvrgb_pkg::UNIT_W{1'b0}}, a} * {{hsvrgb_pkg::UNIT_W{1'b0}}, b};

	// both operands are at most one, so the shifted product fits the unit width
	assign p = prod[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::UNIT_W];

endmodule

`default_nettype wire

>>> rtl/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker: port-level checks for the converter
// tracks pixels in flight and checks stall and output behavior
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_checker (
	input wire clk,
	input wire arst_n,
	input wire hsv_valid,
	input wire hsv_ready,
	input wire rgb_valid,
	input wire rgb_ready
);

	logic [hsvrgb_pkg::CNT_W-1:0] inflight_q;
	logic                         in_xfer, out_xfer;

	assign in_xfer  = hsv_valid && hsv_ready;
	assign out_xfer = rgb_valid && rgb_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + hsvrgb_pkg::CNT_W'(in_xfer)
				- hsvrgb_pkg::CNT_W'(out_xfer);
		end
	end

	// a shown result is not withdrawn before its transfer
	`HSVRGB_ASSERT_NEXT(a_rgb_hold, clk, arst_n, rgb_valid && !rgb_ready, rgb_valid)

	// input back-pressure only comes from a stalled output with the pipe full
	`HSVRGB_ASSERT_IMPL(a_stall_src, clk, arst_n, !hsv_ready, rgb_valid && !rgb_ready)

	// no result without a pixel in flight
	`HSVRGB_ASSERT_IMPL(a_no_phantom, clk, arst_n, rgb_valid, inflight_q != '0)

	// never more pixels in flight than stages
	`HSVRGB_ASSERT_IMPL(a_depth, clk, arst_n, 1'b1,
		inflight_q <= hsvrgb_pkg::CNT_W'(hsvrgb_pkg::PIPE_STAGES))

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_ready (hsv_ready),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready)
);

`default_nettype wire
